/* rtl/core/stlg_pkg.sv */
// Package for the swept-tone leader generator: widths, register indexes,
// multiplier operand codes, the controller command struct and the sine table function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stlg_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 256;
  localparam int PHASE_BITS_DEF       = 32;
  localparam int LENGTH_BITS_DEF      = 24;

  localparam int FREQ_W     = 48;
  localparam int FREQ_FRAC  = 16;
  localparam int STEP_W     = 16;
  localparam int AMP_W      = 16;
  localparam int ENV_W      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int ROM_W      = 15;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 16;
  localparam int PROD_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [ENV_W-1:0] ENV_ONE     = 16'h8000;
  localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd6;

  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_J_RSTEP = 2'd0;
  localparam mul_sel_t MUL_U_U     = 2'd1;
  localparam mul_sel_t MUL_S_ENV   = 2'd2;
  localparam mul_sel_t MUL_P_AMP   = 2'd3;

  typedef struct packed {
    logic     start;
    logic     prep;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     env_addr;
    logic     env_load;
    logic     out_load;
  } stlg_cmd_t;

  // Sine of a Q30 angle in radians, scaled to 32767, rounded and capped.
  // It is evaluated only at elaboration, to build the constant table.
  function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    begin
      y2   = (y * y) >> 30;
      term = y;
      sum  = y;
      term = ((term * y2) >> 30) / 64'd6;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * y2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * y2) >> 30) / 64'd42;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * y2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * y2) >> 30) / 64'd110;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * y2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * y2) >> 30) / 64'd210;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * y2) >> 30) / 64'd272;
      sum  = sum + term;
      v = (sum * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return v[ROM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/stlg_channels.sv */
// Channel interfaces of the swept-tone leader generator: tick input, sample
// output and configuration write. Depends on stlg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stlg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface stlg_out_if
  import stlg_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink (input valid, input sample, input last, input active, output ready);
endinterface

interface stlg_cfg_if
  import stlg_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/stlg_sine_rom.sv */
// Quarter-wave sine table with two read ports and registered read data.
// Depends on stlg_pkg for the table function and widths.
`timescale 1ns / 1ps
`default_nettype none

module stlg_sine_rom
  import stlg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int KW               = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic [KW-1:0]    addr_a,
  input  wire logic [KW-1:0]    addr_b,
  output logic      [ROM_W-1:0] data_a,
  output logic      [ROM_W-1:0] data_b
);

  logic [ROM_W-1:0] tab [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] Y = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    localparam logic [ROM_W-1:0] ENTRY = sine_entry(Y);
    assign tab[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data_a <= tab[addr_a];
    data_b <= tab[addr_b];
  end

endmodule

`default_nettype wire

/* rtl/core/stlg_ctrl.sv */
// Sequencer of the swept-tone leader generator: steps each item through the
// shared multiplier and table reads and owns the output valid flag. Depends on stlg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stlg_ctrl
  import stlg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output stlg_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_MJ   = 4'd2;
  localparam logic [3:0] S_KE   = 4'd3;
  localparam logic [3:0] S_RU   = 4'd4;
  localparam logic [3:0] S_MU   = 4'd5;
  localparam logic [3:0] S_EN   = 4'd6;
  localparam logic [3:0] S_MS   = 4'd7;
  localparam logic [3:0] S_MA   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       can_load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign can_load  = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_J_RSTEP;
    state_nxt    = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MJ;
      end
      S_MJ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_J_RSTEP;
        state_nxt   = S_KE;
      end
      S_KE: begin
        cmd.env_addr = 1'b1;
        state_nxt    = S_RU;
      end
      S_RU: begin
        state_nxt = S_MU;
      end
      S_MU: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_U_U;
        state_nxt   = S_EN;
      end
      S_EN: begin
        cmd.env_load = 1'b1;
        state_nxt    = S_MS;
      end
      S_MS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_S_ENV;
        state_nxt   = S_MA;
      end
      S_MA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P_AMP;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stlg_datapath.sv */
// Datapath of the swept-tone leader generator: configuration registers, chirp
// state, envelope position, shared multiplier and output register.
// Depends on stlg_pkg, stlg_cfg_if and stlg_sine_rom.
`timescale 1ns / 1ps
`default_nettype none

module stlg_datapath
  import stlg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int LENGTH_BITS      = LENGTH_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  stlg_cfg_if.sink               cfg,
  input  wire stlg_cmd_t         cmd,
  input  wire logic              restart,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                   last,
  output logic                   active
);

  localparam int LB         = LENGTH_BITS;
  localparam int PB         = PHASE_BITS;
  localparam int QUAD_SHIFT = PHASE_BITS - 2;
  localparam int KW         = $clog2(SINE_TABLE_DEPTH + 1);

  // Configuration registers.
  logic [LB-1:0]     total_len_r;
  logic [LB-1:0]     sweep_len_r;
  logic [FREQ_W-1:0] start_step_r;
  logic [FREQ_W-1:0] sweep_step_r;
  logic [LB-2:0]     ramp_len_r;
  logic [STEP_W-1:0] ramp_step_r;
  logic [AMP_W-1:0]  amp_r;

  // Chirp state.
  logic [PB-1:0]     phase_r, phase_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [LB-1:0]     idx_r, idx_nxt;
  logic [LB-1:0]     sweep_r, sweep_nxt;
  logic              run_r, run_nxt;

  // Working registers of the item in flight.
  logic [PB-1:0]       p_r;
  logic [LB-1:0]       i_r;
  logic                act_r;
  logic                last_r;
  logic [LB-1:0]       j_r;
  logic                ramp_r;
  logic [KW-1:0]       sk_r;
  logic                neg_r;
  logic [KW-1:0]       ke_r;
  logic [ENV_W-1:0]    env_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ROM_W-1:0]    smag;
  logic [ROM_W-1:0]    u_val;

  // Output register.
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_out_r;
  logic                       active_out_r;

  // Start of item.
  logic [PB-1:0]     eff_phase;
  logic [FREQ_W-1:0] eff_freq;
  logic [LB-1:0]     eff_idx;
  logic [LB-1:0]     eff_sweep;
  logic              eff_run;
  logic [LB:0]       eff_idx1;
  logic              eff_last;
  logic [LB-1:0]     sweep_n;
  logic [LB:0]       sweep_pos1;

  // Envelope position and sine address.
  logic [LB-1:0]         half_n;
  logic [LB-1:0]         ramp_ext;
  logic [LB-1:0]         r_eff;
  logic [LB:0]           i_plus_1;
  logic [LB:0]           i_plus_r;
  logic [LB-1:0]         j_nxt;
  logic                  ramp_nxt;
  logic [QUAD_SHIFT-1:0] frac;
  logic [63:0]           k_full;
  logic [KW-1:0]         k_sin;
  logic [KW-1:0]         sk_nxt;

  // Envelope table address.
  logic [16:0] angle;
  logic [31:0] ke_full;
  logic [KW-1:0] ke_nxt;

  // Multiplier and output.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_nxt;
  logic [46:0]        mag_full;
  logic [SAMPLE_W-1:0] mag;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_len_r  <= '0;
      sweep_len_r  <= LB'(1);
      start_step_r <= '0;
      sweep_step_r <= '0;
      ramp_len_r   <= '0;
      ramp_step_r  <= '0;
      amp_r        <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TOTAL_LENGTH: total_len_r  <= cfg.data[LB-1:0];
        REG_SWEEP_LENGTH: sweep_len_r  <= cfg.data[LB-1:0];
        REG_START_STEP:   start_step_r <= cfg.data[FREQ_W-1:0];
        REG_SWEEP_STEP:   sweep_step_r <= cfg.data[FREQ_W-1:0];
        REG_RAMP_LENGTH:  ramp_len_r   <= cfg.data[LB-2:0];
        REG_RAMP_STEP:    ramp_step_r  <= cfg.data[STEP_W-1:0];
        REG_AMPLITUDE:    amp_r        <= cfg.data[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A restart resets the chirp before this item's sample is taken.
  always_comb begin
    eff_phase  = restart ? '0 : phase_r;
    eff_freq   = restart ? start_step_r : freq_r;
    eff_idx    = restart ? '0 : idx_r;
    eff_sweep  = restart ? '0 : sweep_r;
    eff_run    = restart ? (total_len_r != '0) : run_r;
    eff_idx1   = {1'b0, eff_idx} + (LB + 1)'(1);
    eff_last   = (eff_idx1 >= {1'b0, total_len_r});
    sweep_n    = (sweep_len_r == '0) ? LB'(1) : sweep_len_r;
    sweep_pos1 = {1'b0, eff_sweep} + (LB + 1)'(1);

    phase_nxt = phase_r;
    freq_nxt  = freq_r;
    idx_nxt   = idx_r;
    sweep_nxt = sweep_r;
    run_nxt   = run_r;
    if (cmd.start) begin
      if (eff_run) begin
        phase_nxt = eff_phase + PB'(eff_freq[FREQ_W-1:FREQ_FRAC]);
        if (sweep_pos1 >= {1'b0, sweep_n}) begin
          sweep_nxt = '0;
          freq_nxt  = start_step_r;
        end else begin
          sweep_nxt = sweep_pos1[LB-1:0];
          freq_nxt  = eff_freq + sweep_step_r;
        end
        idx_nxt = eff_idx1[LB-1:0];
        run_nxt = !eff_last;
      end else begin
        phase_nxt = eff_phase;
        freq_nxt  = eff_freq;
        idx_nxt   = eff_idx;
        sweep_nxt = eff_sweep;
        run_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      freq_r  <= '0;
      idx_r   <= '0;
      sweep_r <= '0;
      run_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      freq_r  <= freq_nxt;
      idx_r   <= idx_nxt;
      sweep_r <= sweep_nxt;
      run_r   <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r    <= eff_phase;
      i_r    <= eff_idx;
      act_r  <= eff_run;
      last_r <= eff_run && eff_last;
    end
  end

  // Ramp position and sine table address.
  always_comb begin
    half_n   = total_len_r >> 1;
    ramp_ext = LB'(ramp_len_r);
    r_eff    = (ramp_ext > half_n) ? half_n : ramp_ext;
    i_plus_1 = {1'b0, i_r} + (LB + 1)'(1);
    i_plus_r = {1'b0, i_r} + {1'b0, r_eff};
    j_nxt    = '0;
    ramp_nxt = 1'b0;
    if (r_eff != '0) begin
      if (i_r < r_eff) begin
        ramp_nxt = 1'b1;
        j_nxt    = i_r;
      end else if (i_plus_r >= {1'b0, total_len_r}) begin
        ramp_nxt = 1'b1;
        if ({1'b0, total_len_r} > i_plus_1) begin
          j_nxt = total_len_r - i_r - LB'(1);
        end
      end
    end

    frac   = p_r[QUAD_SHIFT-1:0];
    k_full = (64'(frac) * 64'(SINE_TABLE_DEPTH)) >> QUAD_SHIFT;
    k_sin  = k_full[KW-1:0];
    sk_nxt = p_r[PB-2] ? (KW'(SINE_TABLE_DEPTH) - k_sin) : k_sin;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      j_r    <= j_nxt;
      ramp_r <= ramp_nxt;
      sk_r   <= sk_nxt;
      neg_r  <= p_r[PB-1];
    end
  end

  // Envelope angle saturates at one quarter turn, the end of the quarter-wave table.
  always_comb begin
    angle   = (prod_r > PROD_W'(65536)) ? 17'h10000 : prod_r[16:0];
    ke_full = (32'(angle) * 32'(SINE_TABLE_DEPTH)) >> 16;
    ke_nxt  = (ke_full > 32'(SINE_TABLE_DEPTH)) ? KW'(SINE_TABLE_DEPTH) : ke_full[KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.env_addr) begin
      ke_r <= ke_nxt;
    end
    if (cmd.env_load) begin
      env_r <= ramp_r ? ENV_W'((32'(prod_r[29:0]) + 32'd16384) >> 15) : ENV_ONE;
    end
  end

  stlg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .KW               (KW)
  ) u_rom (
    .clk    (clk),
    .addr_a (sk_r),
    .addr_b (ke_r),
    .data_a (smag),
    .data_b (u_val)
  );

  always_comb begin
    case (cmd.mul_sel)
      MUL_J_RSTEP: begin
        mul_a = MUL_A_W'(j_r);
        mul_b = ramp_step_r;
      end
      MUL_U_U: begin
        mul_a = MUL_A_W'(u_val);
        mul_b = MUL_B_W'(u_val);
      end
      MUL_S_ENV: begin
        mul_a = MUL_A_W'(smag);
        mul_b = env_r;
      end
      MUL_P_AMP: begin
        mul_a = MUL_A_W'(prod_r[29:0]);
        mul_b = amp_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    mag_full = (47'(prod_r[45:0]) + 47'h0000_4000_0000) >> 31;
    mag      = mag_full[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (act_r) begin
        sample_r <= neg_r ? -$signed(mag) : $signed(mag);
      end else begin
        sample_r <= '0;
      end
      last_out_r   <= last_r;
      active_out_r <= act_r;
    end
  end

  assign sample = sample_r;
  assign last   = last_out_r;
  assign active = active_out_r;

endmodule

`default_nettype wire

/* rtl/core/swept_tone_leader_generator_top.sv */
// Top level of the swept-tone leader generator: joins the channels to the
// sequencer and the datapath. Depends on stlg_pkg, the channel interfaces,
// stlg_ctrl and stlg_datapath.
//
// Each item on the tick channel (in_ch) asks for one audio sample; its restart
// bit begins a new leader at sample zero and phase zero. The result channel
// (out_ch) returns one item per tick: a signed 16-bit sample of the enveloped
// chirp, a last flag on the final sample and an active flag while the leader runs.
// Idle ticks return a zero, inactive sample.
// Registers are written through cfg_ch, which is always ready; they are meant to
// be written while no tick is in flight.
// An item is accepted only when the sequencer is idle. It then steps through the states
// PREP, MJ, KE, RU, MU, EN, MS and MA to OUT, which loads the result into the output
// register; only back in IDLE is the next item accepted. The sequence is set by the
// single shared multiplier, used four times per sample, and the registered table reads.
// When the receiver stalls, the held result stays valid and one further item is
// accepted and computed; it waits in the sequencer until the output register frees.
// Reset sets configuration, chirp and sequencer to defaults; the leader is left idle.
`timescale 1ns / 1ps
`default_nettype none

module swept_tone_leader_generator_top
  import stlg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int LENGTH_BITS      = LENGTH_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  stlg_in_if.sink     in_ch,
  stlg_out_if.source  out_ch,
  stlg_cfg_if.sink    cfg_ch
);

  stlg_cmd_t cmd;

  stlg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  stlg_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS),
    .LENGTH_BITS      (LENGTH_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_ch),
    .cmd     (cmd),
    .restart (in_ch.restart),
    .sample  (out_ch.sample),
    .last    (out_ch.last),
    .active  (out_ch.active)
  );

endmodule

`default_nettype wire
